>>> hw/rtl/ipr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ipr_pkg;

	// defaults for the top-level parameters
	localparam int MAX_SCALE_DEF   = 8;
	localparam int MAX_WIDTH_DEF   = 1024;
	localparam int OFFSET_BITS_DEF = 24;

	localparam int HEIGHT_LIMIT = 1024;
	localparam int QUEUE_DEPTH  = 4;

	localparam int SCALE_W = 4;
	localparam int POS_W   = 10;
	localparam int SIZE_W  = 11;
	localparam int CFG_W   = 14;
	localparam int INDEX_W = 3;
	localparam int FB_W    = 24;

	// register indexes
	localparam logic [INDEX_W-1:0] REG_SCALE_X  = 3'd0;
	localparam logic [INDEX_W-1:0] REG_SCALE_Y  = 3'd1;
	localparam logic [INDEX_W-1:0] REG_LEFT     = 3'd2;
	localparam logic [INDEX_W-1:0] REG_TOP      = 3'd3;
	localparam logic [INDEX_W-1:0] REG_STRIDE   = 3'd4;
	localparam logic [INDEX_W-1:0] REG_WIDTH    = 3'd5;
	localparam logic [INDEX_W-1:0] REG_HEIGHT   = 3'd6;
	localparam logic [INDEX_W-1:0] REG_ENABLE   = 3'd7;

	typedef struct packed {
		logic [7:0] pixel;
		logic       frame_start;
	} in_word_t;

	typedef struct packed {
		logic [FB_W-1:0] fb_offset;
		logic [7:0]      value;
		logic            last_of_run;
		logic            last_of_frame;
	} out_word_t;

	// clamped settings as seen by the datapath
	typedef struct packed {
		logic [SCALE_W-1:0] scale_x;
		logic [SCALE_W-1:0] scale_y;
		logic [11:0]        left_offset;
		logic [11:0]        top_offset;
		logic [CFG_W-1:0]   line_stride;
		logic [SIZE_W-1:0]  width;
		logic [SIZE_W-1:0]  height;
		logic               enable;
	} cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/integer_pixel_replication_scaler.sv
`timescale 1ns / 1ps
`default_nettype none

// Pixel replication upscaler: source pixels in, frame-buffer byte writes out.
// Input side looks like a queue: drive in_data and raise push; the word is
// taken on a clock edge where full is low. Output side is a queue too: while
// empty is low out_data holds the oldest write; pop takes it.
// Config: cfg_valid/cfg_ready (ready is always high) with cfg_index selecting
// scale_x, scale_y, left_offset, top_offset, line_stride, source_width,
// source_height, enable (0..7). Write only with the block drained.
// Each enabled pixel gives scale_x * scale_y writes, one per cycle while the
// output register is free or being popped, so the back end sets throughput.
// Disabled pixels only move the position, one per cycle while full is low.
// After a pixel is taken its first write passes the front stage, the queue,
// the replica walker and the output register.
// A 4-deep queue between the front (position tracking) and the back
// (replica walk) lets the front keep taking pixels while the back works.
// When pop stays low the output register holds, the walker stops, the queue
// fills and full rises; nothing is dropped.
// Reset: registers to their defaults, position at column 0, row 0, line
// base 0, all queues empty.
module integer_pixel_replication_scaler #(
	parameter int MAX_SCALE   = ipr_pkg::MAX_SCALE_DEF,
	parameter int MAX_WIDTH   = ipr_pkg::MAX_WIDTH_DEF,
	parameter int OFFSET_BITS = ipr_pkg::OFFSET_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	output logic                             full,
	input  wire ipr_pkg::in_word_t           in_data,
	output logic                             empty,
	input  wire logic                        pop,
	output ipr_pkg::out_word_t               out_data,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [ipr_pkg::INDEX_W-1:0] cfg_index,
	input  wire logic [ipr_pkg::CFG_W-1:0]   cfg_data
);
	import ipr_pkg::*;

	// queue word: block origin offset, pixel, last-of-frame flag
	localparam int QW = OFFSET_BITS + 9;

	cfg_t          cfg;
	logic          q_push, q_full, q_pop, q_empty;
	logic [QW-1:0] q_wdata, q_rdata;

	assign cfg_ready = 1'b1;

	ipr_cfg #(
		.MAX_SCALE (MAX_SCALE),
		.MAX_WIDTH (MAX_WIDTH)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	ipr_front #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.push    (push),
		.in_data (in_data),
		.full    (full),
		.q_push  (q_push),
		.q_data  (q_wdata),
		.q_full  (q_full)
	);

	ipr_queue #(
		.W     (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_push),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd      (q_pop),
		.rd_data (q_rdata),
		.empty   (q_empty)
	);

	ipr_back #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_empty  (q_empty),
		.q_data   (q_rdata),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

>>> hw/rtl/ipr_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module ipr_cfg #(
	parameter int MAX_SCALE = ipr_pkg::MAX_SCALE_DEF,
	parameter int MAX_WIDTH = ipr_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       wr_en,
	input  wire logic [ipr_pkg::INDEX_W-1:0] wr_index,
	input  wire logic [ipr_pkg::CFG_W-1:0]   wr_data,
	output ipr_pkg::cfg_t                   cfg
);
	import ipr_pkg::*;

	logic [SCALE_W-1:0] scale_x_q, scale_y_q;
	logic [11:0]        left_q, top_q;
	logic [CFG_W-1:0]   stride_q;
	logic [SIZE_W-1:0]  width_q, height_q;
	logic               enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q <= SCALE_W'(1);
			scale_y_q <= SCALE_W'(1);
			left_q    <= '0;
			top_q     <= '0;
			stride_q  <= CFG_W'(1024);
			width_q   <= SIZE_W'(256);
			height_q  <= SIZE_W'(192);
			enable_q  <= 1'b1;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SCALE_X: scale_x_q <= wr_data[SCALE_W-1:0];
				REG_SCALE_Y: scale_y_q <= wr_data[SCALE_W-1:0];
				REG_LEFT:    left_q    <= wr_data[11:0];
				REG_TOP:     top_q     <= wr_data[11:0];
				REG_STRIDE:  stride_q  <= wr_data;
				REG_WIDTH:   width_q   <= wr_data[SIZE_W-1:0];
				REG_HEIGHT:  height_q  <= wr_data[SIZE_W-1:0];
				REG_ENABLE:  enable_q  <= wr_data[0];
				default: ;
			endcase
		end
	end

	// scales, width and height: zero reads as one, large values saturate
	always_comb begin
		cfg.scale_x = (scale_x_q == '0) ? SCALE_W'(1) :
			(scale_x_q > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : scale_x_q;
		cfg.scale_y = (scale_y_q == '0) ? SCALE_W'(1) :
			(scale_y_q > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : scale_y_q;
		cfg.width = (width_q == '0) ? SIZE_W'(1) :
			({2'b00, width_q} > 13'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : width_q;
		cfg.height = (height_q == '0) ? SIZE_W'(1) :
			(height_q > SIZE_W'(HEIGHT_LIMIT)) ? SIZE_W'(HEIGHT_LIMIT) : height_q;
		cfg.left_offset = left_q;
		cfg.top_offset  = top_q;
		cfg.line_stride = stride_q;
		cfg.enable      = enable_q;
	end

endmodule

`default_nettype wire

>>> hw/rtl/ipr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ipr_front #(
	parameter int OFFSET_BITS = ipr_pkg::OFFSET_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ipr_pkg::cfg_t      cfg,
	input  wire logic               push,
	input  wire ipr_pkg::in_word_t  in_data,
	output logic                    full,
	output logic                    q_push,
	output logic [OFFSET_BITS+8:0]  q_data,
	input  wire logic               q_full
);
	import ipr_pkg::*;

	localparam int OB = OFFSET_BITS;

	logic [POS_W-1:0] column_q, row_q;
	logic [OB-1:0]    row_base_q;

	logic             valid_s1;
	logic [OB-1:0]    rb_s1;
	logic [POS_W-1:0] col_s1;
	logic [7:0]       pix_s1;
	logic             fe_s1;

	logic             accept;
	logic [POS_W-1:0] eff_col, eff_row;
	logic [OB-1:0]    eff_rb, origin, origin_next, rb_step;
	logic [SIZE_W-1:0] col_inc, row_inc;
	logic             line_end, frame_end;
	logic [OB-1:0]    base;

	assign full   = valid_s1 && q_full;
	assign accept = push && !full;
	assign q_push = valid_s1 && !q_full;

	// frame origin, origin one source line down, and next line base
	assign origin      = OB'(cfg.top_offset) * OB'(cfg.line_stride) + OB'(cfg.left_offset);
	assign origin_next = (OB'(cfg.top_offset) + OB'(cfg.scale_y)) * OB'(cfg.line_stride)
		+ OB'(cfg.left_offset);
	assign rb_step     = row_base_q + OB'(cfg.scale_y) * OB'(cfg.line_stride);

	always_comb begin
		eff_col   = in_data.frame_start ? '0 : column_q;
		eff_row   = in_data.frame_start ? '0 : row_q;
		eff_rb    = in_data.frame_start ? origin : row_base_q;
		col_inc   = SIZE_W'(eff_col) + SIZE_W'(1);
		row_inc   = SIZE_W'(eff_row) + SIZE_W'(1);
		// past-the-end positions also count as last
		line_end  = col_inc >= cfg.width;
		frame_end = line_end && (row_inc >= cfg.height);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q   <= '0;
			row_q      <= '0;
			row_base_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				column_q   <= '0;
				row_q      <= '0;
				row_base_q <= origin;
			end else if (line_end) begin
				column_q   <= '0;
				row_q      <= row_inc[POS_W-1:0];
				row_base_q <= in_data.frame_start ? origin_next : rb_step;
			end else begin
				column_q   <= col_inc[POS_W-1:0];
				row_q      <= eff_row;
				row_base_q <= eff_rb;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= cfg.enable;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rb_s1  <= eff_rb;
			col_s1 <= eff_col;
			pix_s1 <= in_data.pixel;
			fe_s1  <= frame_end;
		end
	end

	assign base   = rb_s1 + OB'(col_s1) * OB'(cfg.scale_x);
	assign q_data = {base, pix_s1, fe_s1};

endmodule

`default_nettype wire

>>> hw/rtl/ipr_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ipr_queue #(
	parameter int W     = 33,
	parameter int DEPTH = ipr_pkg::QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr,
	input  wire logic [W-1:0] wr_data,
	output logic              full,
	input  wire logic         rd,
	output logic [W-1:0]      rd_data,
	output logic              empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full    = count_q == CNT_W'(DEPTH);
	assign empty   = count_q == '0;
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/ipr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ipr_back #(
	parameter int OFFSET_BITS = ipr_pkg::OFFSET_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire ipr_pkg::cfg_t           cfg,
	input  wire logic                    q_empty,
	input  wire logic [OFFSET_BITS+8:0]  q_data,
	output logic                         q_pop,
	output logic                         empty,
	input  wire logic                    pop,
	output ipr_pkg::out_word_t           out_data
);
	import ipr_pkg::*;

	localparam int OB = OFFSET_BITS;

	logic               busy_q;
	logic [OB-1:0]      line_base_q, cur_q;
	logic [7:0]         pix_q;
	logic               fe_q;
	logic [SCALE_W-1:0] i_q, j_q;

	logic               out_valid_q;
	out_word_t          out_q;

	logic               adv, last_i, last_j, last_all;
	logic [OB-1:0]      next_line;

	assign adv       = busy_q && (!out_valid_q || pop);
	assign last_i    = (i_q + SCALE_W'(1)) == cfg.scale_x;
	assign last_j    = (j_q + SCALE_W'(1)) == cfg.scale_y;
	assign last_all  = last_i && last_j;
	assign q_pop     = !q_empty && (!busy_q || (adv && last_all));
	assign next_line = line_base_q + OB'(cfg.line_stride);

	// replica walk: lines top to bottom, bytes left to right
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
		end else if (adv && last_all) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			line_base_q <= q_data[OB+8:9];
			cur_q       <= q_data[OB+8:9];
			pix_q       <= q_data[8:1];
			fe_q        <= q_data[0];
			i_q         <= '0;
			j_q         <= '0;
		end else if (adv) begin
			if (last_i) begin
				i_q         <= '0;
				j_q         <= j_q + SCALE_W'(1);
				line_base_q <= next_line;
				cur_q       <= next_line;
			end else begin
				i_q   <= i_q + SCALE_W'(1);
				cur_q <= cur_q + OB'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.fb_offset     <= FB_W'(cur_q);
			out_q.value         <= pix_q;
			out_q.last_of_run   <= last_all;
			out_q.last_of_frame <= last_all && fe_q;
		end
	end

	assign empty    = !out_valid_q;
	assign out_data = out_q;

endmodule

`default_nettype wire
